/* sv/ipv6f_pkg.sv */
`timescale 1ns / 1ps

package ipv6f_pkg;

    localparam int NUM_WORDS = 8;

    localparam logic [6:0] CHAR_COLON = 7'h3A;
    localparam logic [6:0] CHAR_ZERO  = 7'h30;
    localparam logic [6:0] CHAR_LC_A  = 7'h61;

    // One address, already analysed: words, digit counts and the run to compress.
    typedef struct packed {
        logic [NUM_WORDS-1:0][15:0] words;
        logic [NUM_WORDS-1:0][2:0]  ndig;       // 1..4 significant hex digits
        logic [2:0]                 best_start;
        logic [3:0]                 best_len;   // 0 = no run, else 2..8
    } item_t;

    function automatic logic [6:0] hex_char(input logic [3:0] nib);
        logic [6:0] code;
        if (nib < 4'd10)
        begin
            code = CHAR_ZERO + {3'b000, nib};
        end
        else
        begin
            code = CHAR_LC_A + {3'b000, nib - 4'd10};
        end
        return code;
    endfunction

endpackage

/* sv/ipv6f_lane.sv */
`timescale 1ns / 1ps

// One word lane: zero flag and number of significant hex digits.
module ipv6f_lane (
    input  logic [15:0] word,
    output logic        is_zero,
    output logic [2:0]  ndig
);

    assign is_zero = (word == 16'h0000);

    always_comb
    begin
        if (word[15:12] != 4'h0)
        begin
            ndig = 3'd4;
        end
        else if (word[11:8] != 4'h0)
        begin
            ndig = 3'd3;
        end
        else if (word[7:4] != 4'h0)
        begin
            ndig = 3'd2;
        end
        else
        begin
            ndig = 3'd1;
        end
    end

endmodule

/* sv/ipv6f_merge.sv */
`timescale 1ns / 1ps

// Combines the lane zero flags: first longest run of two or more zero words.
module ipv6f_merge (
    input  logic [ipv6f_pkg::NUM_WORDS-1:0] zero,
    output logic [2:0]                      best_start,
    output logic [3:0]                      best_len
);

    logic [ipv6f_pkg::NUM_WORDS-1:0]      run_head;
    logic [ipv6f_pkg::NUM_WORDS-1:0][3:0] run_len;

    // Run length from every word, each lane independently.
    always_comb
    begin
        logic going;
        for (int s = 0; s < ipv6f_pkg::NUM_WORDS; s++)
        begin
            run_head[s] = zero[s] && ((s == 0) || !zero[(s == 0) ? 0 : s - 1]);
            run_len[s]  = 4'd0;
            going       = 1'b1;
            for (int k = s; k < ipv6f_pkg::NUM_WORDS; k++)
            begin
                going = going && zero[k];
                if (going)
                begin
                    run_len[s] = run_len[s] + 4'd1;
                end
            end
        end
    end

    // Strict compare keeps the earliest of equal runs.
    always_comb
    begin
        best_start = 3'd0;
        best_len   = 4'd0;
        for (int s = 0; s < ipv6f_pkg::NUM_WORDS; s++)
        begin
            if (run_head[s] && (run_len[s] > best_len) && (run_len[s] > 4'd1))
            begin
                best_start = 3'(s);
                best_len   = run_len[s];
            end
        end
    end

endmodule

/* sv/ipv6f_emit.sv */
`timescale 1ns / 1ps

// Character sequencer: one character per cycle from an analysed item.
module ipv6f_emit (
    input  logic                 clk,
    input  logic                 rst_n,
    input  ipv6f_pkg::item_t     pend,
    input  logic                 pend_valid,
    output logic                 load,
    output logic [6:0]           char_code,
    output logic                 last_char,
    output logic                 char_valid
);

    localparam logic [1:0] MODE_DIG  = 2'd0;
    localparam logic [1:0] MODE_SEP  = 2'd1;
    localparam logic [1:0] MODE_RUN1 = 2'd2;
    localparam logic [1:0] MODE_RUN2 = 2'd3;

    ipv6f_pkg::item_t item_reg;
    logic             active_reg, active_next;
    logic [1:0]       mode_reg, mode_next;
    logic [2:0]       wi_reg, wi_next;
    logic [1:0]       dp_reg, dp_next;
    logic [6:0]       char_reg, char_next;
    logic             last_reg;
    logic             valid_reg;

    logic             cur_last;
    logic             run_to_end;
    logic [3:0]       after_run;
    logic [3:0]       next_word;
    logic [15:0]      cur_word;
    logic [2:0]       dig_tmp;

    assign after_run  = {1'b0, item_reg.best_start} + item_reg.best_len;
    assign run_to_end = (after_run == 4'd8);
    assign next_word  = {1'b0, wi_reg} + 4'd1;
    assign cur_word   = item_reg.words[wi_reg];

    assign cur_last = active_reg &&
                      (((mode_reg == MODE_DIG) && (dp_reg == 2'd0) && (wi_reg == 3'd7)) ||
                       ((mode_reg == MODE_RUN2) && run_to_end));
    assign load = pend_valid && (!active_reg || cur_last);

    always_comb
    begin
        case (mode_reg)
            MODE_DIG:
            begin
                char_next = ipv6f_pkg::hex_char(cur_word[{dp_reg, 2'b00} +: 4]);
            end
            default:
            begin
                char_next = ipv6f_pkg::CHAR_COLON;
            end
        endcase
    end

    always_comb
    begin
        active_next = active_reg;
        mode_next   = mode_reg;
        wi_next     = wi_reg;
        dp_next     = dp_reg;
        dig_tmp     = 3'd0;
        if (load)
        begin
            active_next = 1'b1;
            wi_next     = 3'd0;
            dig_tmp     = pend.ndig[0] - 3'd1;
            dp_next     = dig_tmp[1:0];
            if ((pend.best_len != 4'd0) && (pend.best_start == 3'd0))
            begin
                mode_next = MODE_RUN1;
            end
            else
            begin
                mode_next = MODE_DIG;
            end
        end
        else if (cur_last)
        begin
            active_next = 1'b0;
        end
        else if (active_reg)
        begin
            case (mode_reg)
                MODE_RUN1:
                begin
                    mode_next = MODE_RUN2;
                end
                MODE_RUN2:
                begin
                    // Word after the run follows the colons directly.
                    wi_next   = after_run[2:0];
                    dig_tmp   = item_reg.ndig[after_run[2:0]] - 3'd1;
                    dp_next   = dig_tmp[1:0];
                    mode_next = MODE_DIG;
                end
                MODE_SEP:
                begin
                    dig_tmp   = item_reg.ndig[wi_reg] - 3'd1;
                    dp_next   = dig_tmp[1:0];
                    mode_next = MODE_DIG;
                end
                default:
                begin
                    if (dp_reg != 2'd0)
                    begin
                        dp_next = dp_reg - 2'd1;
                    end
                    else
                    begin
                        wi_next = next_word[2:0];
                        if ((item_reg.best_len != 4'd0) &&
                            (item_reg.best_start == next_word[2:0]))
                        begin
                            mode_next = MODE_RUN1;
                        end
                        else
                        begin
                            mode_next = MODE_SEP;
                        end
                    end
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_reg <= 1'b0;
            mode_reg   <= MODE_DIG;
            wi_reg     <= 3'd0;
            dp_reg     <= 2'd0;
            valid_reg  <= 1'b0;
            last_reg   <= 1'b0;
        end
        else
        begin
            active_reg <= active_next;
            mode_reg   <= mode_next;
            wi_reg     <= wi_next;
            dp_reg     <= dp_next;
            valid_reg  <= active_reg;
            last_reg   <= cur_last;
        end
    end

    always_ff @(posedge clk)
    begin
        char_reg <= char_next;
        if (load)
        begin
            item_reg <= pend;
        end
    end

    assign char_code  = char_reg;
    assign last_char  = last_reg;
    assign char_valid = valid_reg;

endmodule

/* sv/ipv6_text_formatter_top.sv */
`timescale 1ns / 1ps

// IPv6 address to canonical text. Pulse start with addr_high/addr_low while
// busy is low; the address is printed as lower-case hex words without leading
// zeros, separated by colons, with the first longest run of two or more zero
// words written as "::" (an all-zero address gives "::", a trailing run ends
// the text with "::"). Characters come out one per cycle on char_code, each
// marked by char_valid for exactly one cycle, with last_char on the final
// one; the receiver cannot stall, so it must take a character every cycle
// that char_valid is high. An item produces 2 to 39 characters, the
// characters of one item come in consecutive cycles, and when the block is
// idle the item passes through the buffer, the sequencer state and the
// character register before its first character appears. The character
// sequencer sets the rate: one character per clock, and an item holds it
// until its last character. A second item can be accepted while the first
// is still being printed; it is held analysed in a one-item buffer and busy
// stays high only while that buffer is occupied. If the second item is
// buffered before the previous item's last character is sequenced, its text
// follows that character with no gap.
//
// Structure: eight word lanes find zero words and digit counts in parallel,
// a merge stage picks the run to compress, the result is buffered and the sequencer walks the words.
module ipv6_text_formatter_top (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [63:0] addr_high,
    input  logic [63:0] addr_low,
    output logic [6:0]  char_code,
    output logic        last_char,
    output logic        char_valid
);

    logic [ipv6f_pkg::NUM_WORDS-1:0][15:0] words;
    logic [ipv6f_pkg::NUM_WORDS-1:0]       zero;
    logic [ipv6f_pkg::NUM_WORDS-1:0][2:0]  ndig;
    logic [2:0]                            best_start;
    logic [3:0]                            best_len;

    ipv6f_pkg::item_t pend_reg;
    logic             pend_valid_reg, pend_valid_next;
    logic             accept;
    logic             load;

    // Word 0 is the top of addr_high, word 4 the top of addr_low.
    always_comb
    begin
        for (int i = 0; i < 4; i++)
        begin
            words[i]     = addr_high[63 - 16 * i -: 16];
            words[i + 4] = addr_low[63 - 16 * i -: 16];
        end
    end

    for (genvar g = 0; g < ipv6f_pkg::NUM_WORDS; g++)
    begin : g_lane
        ipv6f_lane u_lane (
            .word    (words[g]),
            .is_zero (zero[g]),
            .ndig    (ndig[g])
        );
    end

    ipv6f_merge u_merge (
        .zero       (zero),
        .best_start (best_start),
        .best_len   (best_len)
    );

    assign busy   = pend_valid_reg;
    assign accept = start && !busy;

    // Buffer fills on acceptance and drains when the sequencer takes it.
    always_comb
    begin
        pend_valid_next = pend_valid_reg;
        if (accept)
        begin
            pend_valid_next = 1'b1;
        end
        else if (load)
        begin
            pend_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pend_valid_reg <= 1'b0;
        end
        else
        begin
            pend_valid_reg <= pend_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            pend_reg.words      <= words;
            pend_reg.ndig       <= ndig;
            pend_reg.best_start <= best_start;
            pend_reg.best_len   <= best_len;
        end
    end

    ipv6f_emit u_emit (
        .clk        (clk),
        .rst_n      (rst_n),
        .pend       (pend_reg),
        .pend_valid (pend_valid_reg),
        .load       (load),
        .char_code  (char_code),
        .last_char  (last_char),
        .char_valid (char_valid)
    );

endmodule

/* sv/ipv6f_checker.sv */
`timescale 1ns / 1ps

module ipv6f_checker (
    input logic       clk,
    input logic       rst_n,
    input logic       start,
    input logic       busy,
    input logic [6:0] char_code,
    input logic       last_char,
    input logic       char_valid
);

    // Last marker only rides on a character.
    a_last_on_char: assert property (@(posedge clk) disable iff (!rst_n)
        last_char |-> char_valid)
        else $error("last_char without char_valid");

    // The text of an item is unbroken until its last character.
    a_text_contiguous: assert property (@(posedge clk) disable iff (!rst_n)
        (char_valid && !last_char) |=> char_valid)
        else $error("gap inside an item's text");

    // The text only stops after a last character.
    a_stop_after_last: assert property (@(posedge clk) disable iff (!rst_n)
        $fell(char_valid) |-> $past(last_char))
        else $error("text ended without last_char");

    // An accepted item occupies the buffer for the next cycle.
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> busy)
        else $error("busy not raised after acceptance");

    // Characters are hex digits or colons only.
    a_char_set: assert property (@(posedge clk) disable iff (!rst_n)
        char_valid |-> ((char_code >= 7'h30 && char_code <= 7'h3A) ||
                        (char_code >= 7'h61 && char_code <= 7'h66)))
        else $error("character outside hex and colon");

endmodule

bind ipv6_text_formatter_top ipv6f_checker u_ipv6f_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .start      (start),
    .busy       (busy),
    .char_code  (char_code),
    .last_char  (last_char),
    .char_valid (char_valid)
);
